/* hw/rtl/mbec_pkg.sv */
// Shared constants for the escape-time iteration core.
`timescale 1ns / 1ps
package mbec_pkg;

  // Field widths
  localparam int INDEX_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 16;
  localparam int COORD_W    = 32;
  localparam int CFG_IDX_W  = 3;

  // z after an update stays within +/-2^(FRAC_BITS+4): two extra integer bits over Q4.28
  localparam int ZW     = COORD_W + 2;
  // Shared multiplier operand width: covers coordinates, steps and bounded z
  localparam int MUL_W  = COORD_W + 1;
  // Products: squares of |z| < 2 and index times step
  localparam int PROD_W = 2 * FRAC_BITS + 4;
  // Update sums: product terms plus c aligned to 2F fraction bits
  localparam int SUM_W  = PROD_W + 2;
  // Coordinate sum before saturation
  localparam int CSUM_W = COORD_W + INDEX_BITS + 2;

  // Input beat: pixel_column then pixel_row, padded to whole bytes
  localparam int S_DATA_W = ((2 * INDEX_BITS + 7) / 8) * 8;
  localparam int M_DATA_W = ((COUNT_BITS + 7) / 8) * 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd4;

  localparam logic [COUNT_BITS-1:0] MAX_ITER_RESET = COUNT_BITS'(1024);

endpackage

/* hw/rtl/mandelbrot_escape_count_core.sv */
// Mandelbrot escape-time core: one pixel at a time through a shared multiplier.
// Steps: c is formed in ST_MUL_CR, ST_MUL_CI and ST_SAT_CI; each iteration runs ST_CHECK,
// ST_SQ_I, ST_CROSS and ST_UPD; the run ends in ST_CHECK when the limit or a large component
// ends it, or in ST_CROSS when |z|^2 does, and ST_FIN loads the result. The next input beat
// is taken only once the sequencer is back in idle; a stalled result holds the sequencer.
// Reset (rst_ni low, asynchronous): sequencer idle, output empty, origins/steps zero, limit 1024.
`timescale 1ns / 1ps
module mandelbrot_escape_count_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [mbec_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mbec_pkg::COORD_W-1:0]         cfg_data_i,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mbec_pkg::S_DATA_W-1:0]        s_axis_tdata,   // [11:0] pixel_column, [23:12] pixel_row
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mbec_pkg::M_DATA_W-1:0]        m_axis_tdata    // [15:0] iteration_count
);
  import mbec_pkg::*;

  // Sequencer codes
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_CR = 4'd1;
  localparam logic [3:0] ST_MUL_CI = 4'd2;
  localparam logic [3:0] ST_SAT_CI = 4'd3;
  localparam logic [3:0] ST_CHECK  = 4'd4;
  localparam logic [3:0] ST_SQ_I   = 4'd5;
  localparam logic [3:0] ST_CROSS  = 4'd6;
  localparam logic [3:0] ST_UPD    = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;

  localparam logic signed [ZW-1:0]     TwoZ      = ZW'(1) << (FRAC_BITS + 1);
  localparam logic signed [ZW-1:0]     NegTwoZ   = -TwoZ;
  localparam logic signed [PROD_W:0]   FourWide  = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 2);
  localparam logic signed [CSUM_W-1:0] CoordMax  = (CSUM_W'(1) << (COORD_W - 1)) - CSUM_W'(1);
  localparam logic signed [CSUM_W-1:0] CoordMin  = ~CoordMax;

  logic [3:0] state_q, state_d;

  logic signed [COORD_W-1:0]  rorig_q, iorig_q, rstep_q, istep_q;
  logic [COUNT_BITS-1:0]      max_q;

  logic [INDEX_BITS-1:0]      col_q, row_q;
  logic signed [COORD_W-1:0]  cr_q, ci_q, cr_d, ci_d;
  logic signed [ZW-1:0]       zr_q, zi_q, zr_d, zi_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d, zr2_q, zr2_d;
  logic [COUNT_BITS-1:0]      n_q, n_d;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [2*MUL_W-1:0]  mul_full;
  logic signed [CSUM_W-1:0]   csum;
  logic signed [COORD_W-1:0]  csat;
  logic signed [PROD_W:0]     sq_sum;
  logic signed [SUM_W-1:0]    sum_re, sum_im;
  logic                       big_z, done_lim, escaped_sq;

  logic                       out_valid_q;
  logic [COUNT_BITS-1:0]      out_count_q;
  logic                       out_free, load_out, s_beat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rorig_q <= '0;
      iorig_q <= '0;
      rstep_q <= '0;
      istep_q <= '0;
      max_q   <= MAX_ITER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_REAL_ORIGIN: rorig_q <= $signed(cfg_data_i);
        REG_IMAG_ORIGIN: iorig_q <= $signed(cfg_data_i);
        REG_REAL_STEP:   rstep_q <= $signed(cfg_data_i);
        REG_IMAG_STEP:   istep_q <= $signed(cfg_data_i);
        REG_MAX_ITER:    max_q   <= cfg_data_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (state_q)
      ST_MUL_CR: begin
        mul_a = $signed({{(MUL_W-INDEX_BITS){1'b0}}, col_q});
        mul_b = MUL_W'(rstep_q);
      end
      ST_MUL_CI: begin
        mul_a = $signed({{(MUL_W-INDEX_BITS){1'b0}}, row_q});
        mul_b = MUL_W'(istep_q);
      end
      ST_CHECK: begin
        mul_a = zr_q[MUL_W-1:0];
        mul_b = zr_q[MUL_W-1:0];
      end
      ST_SQ_I: begin
        mul_a = zi_q[MUL_W-1:0];
        mul_b = zi_q[MUL_W-1:0];
      end
      default: begin
        mul_a = zr_q[MUL_W-1:0];
        mul_b = zi_q[MUL_W-1:0];
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign prod_d   = PROD_W'(mul_full);

  // Origin plus index times step, saturated to Q4.28
  always_comb begin
    if (state_q == ST_MUL_CI) begin
      csum = CSUM_W'(rorig_q) + CSUM_W'(prod_q);
    end else begin
      csum = CSUM_W'(iorig_q) + CSUM_W'(prod_q);
    end
    priority if (csum > CoordMax) begin
      csat = COORD_W'(CoordMax);
    end else if (csum < CoordMin) begin
      csat = COORD_W'(CoordMin);
    end else begin
      csat = COORD_W'(csum);
    end
  end

  // Escape tests and the z update datapath
  assign big_z      = (zr_q >= TwoZ) || (zr_q <= NegTwoZ) ||
                      (zi_q >= TwoZ) || (zi_q <= NegTwoZ);
  assign done_lim   = (n_q >= max_q);
  assign sq_sum     = (PROD_W + 1)'(zr2_q) + (PROD_W + 1)'(prod_q);
  assign escaped_sq = (sq_sum >= FourWide);
  assign sum_re     = SUM_W'(zr2_q) - SUM_W'(prod_q) + (SUM_W'(cr_q) <<< FRAC_BITS);
  assign sum_im     = (SUM_W'(prod_q) <<< 1) + (SUM_W'(ci_q) <<< FRAC_BITS);

  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_beat   = s_axis_tvalid && s_axis_tready;
  assign load_out = (state_q == ST_FIN) && out_free;

  // Sequencer
  always_comb begin
    state_d = state_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    zr2_d   = zr2_q;
    n_d     = n_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_MUL_CR;
        end
      end
      ST_MUL_CR: state_d = ST_MUL_CI;
      ST_MUL_CI: begin
        cr_d    = csat;
        state_d = ST_SAT_CI;
      end
      ST_SAT_CI: begin
        ci_d    = csat;
        zr_d    = '0;
        zi_d    = '0;
        n_d     = '0;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (done_lim || big_z) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_SQ_I;
        end
      end
      ST_SQ_I: begin
        zr2_d   = prod_q;
        state_d = ST_CROSS;
      end
      ST_CROSS: begin
        if (escaped_sq) begin
          state_d = ST_FIN;
        end else begin
          zr_d    = ZW'(sum_re >>> FRAC_BITS);
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        zi_d    = ZW'(sum_im >>> FRAC_BITS);
        n_d     = n_q + COUNT_BITS'(1);
        state_d = ST_CHECK;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      col_q <= s_axis_tdata[INDEX_BITS-1:0];
      row_q <= s_axis_tdata[2*INDEX_BITS-1:INDEX_BITS];
    end
    prod_q <= prod_d;
    cr_q   <= cr_d;
    ci_q   <= ci_d;
    zr_q   <= zr_d;
    zi_q   <= zi_d;
    zr2_q  <= zr2_d;
    n_q    <= n_d;
    if (load_out) begin
      out_count_q <= n_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_DATA_W'(out_count_q);

`ifndef SYNTHESIS
  // At the squaring step the real part of z lies inside the |component| < 2 window
  a_sq_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ_I) |-> ((zr_q < TwoZ) && (zr_q > NegTwoZ)))
    else $error("z real part out of range at squaring");

  // An accepted beat starts the coordinate multiply
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> (state_q == ST_MUL_CR))
    else $error("accepted beat did not start the sequencer");

  // A new result appears only out of the finish step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid)) |-> ($past(state_q) == ST_FIN))
    else $error("result loaded outside the finish step");

  // The update step advances the count by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |=> (n_q == $past(n_q) + COUNT_BITS'(1)))
    else $error("iteration count did not advance");
`endif

endmodule

/* dv/mandelbrot_escape_count_core_tb.sv */
// Self-checking testbench for the Mandelbrot escape-count core.
`timescale 1ns / 1ps
module mandelbrot_escape_count_core_tb;
  import mbec_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 20_000_000;
  localparam int          RANDOM_ITEMS = 580;
  localparam int          QUIET_TAIL   = 60;

  // Fixed-point constants for the predictor
  localparam longint UNIT_Q    = longint'(1) <<< FRAC_BITS;
  localparam longint TWO_Q     = 2 * UNIT_Q;
  localparam longint FOUR_WIDE = 4 * UNIT_Q * UNIT_Q;
  localparam longint COORD_HI  = 64'sd2147483647;
  localparam longint COORD_LO  = -64'sd2147483648;

  // Indexes past the last register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;

  // Plane window: re from -2.0 to about 1.0, im from -1.5 to about 0.5
  localparam logic [COORD_W-1:0] VIEW_RE_ORG = 32'hE000_0000;
  localparam logic [COORD_W-1:0] VIEW_IM_ORG = 32'hE800_0000;
  localparam logic [COORD_W-1:0] VIEW_RE_STP = 32'd196608;
  localparam logic [COORD_W-1:0] VIEW_IM_STP = 32'd131072;

  // Predicts escape counts and holds the counts still owed by the core
  class escape_count_board;
    longint                re_origin, im_origin, re_step, im_step;
    int unsigned           iter_limit;
    logic [COUNT_BITS-1:0] counts_due[$];
    int unsigned           mismatches;

    function new();
      re_origin  = 0;
      im_origin  = 0;
      re_step    = 0;
      im_step    = 0;
      iter_limit = MAX_ITER_RESET;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      case (idx)
        REG_REAL_ORIGIN: re_origin = longint'($signed(val));
        REG_IMAG_ORIGIN: im_origin = longint'($signed(val));
        REG_REAL_STEP:   re_step   = longint'($signed(val));
        REG_IMAG_STEP:   im_step   = longint'($signed(val));
        REG_MAX_ITER:    iter_limit = val[COUNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_coord(longint v);
      if (v > COORD_HI) return COORD_HI;
      if (v < COORD_LO) return COORD_LO;
      return v;
    endfunction

    function logic [COUNT_BITS-1:0] escape_count(logic [INDEX_BITS-1:0] col,
                                                 logic [INDEX_BITS-1:0] row);
      longint      cr, ci, zr, zi, zr2, zi2, sum_re, sum_im;
      int unsigned n;
      cr = clamp_coord(re_origin + longint'(col) * re_step);
      ci = clamp_coord(im_origin + longint'(row) * im_step);
      zr = 0;
      zi = 0;
      n  = 0;
      while (n < iter_limit) begin
        // a component at 2.0 or beyond has escaped without squaring
        if (zr >= TWO_Q || zr <= -TWO_Q || zi >= TWO_Q || zi <= -TWO_Q) break;
        zr2 = zr * zr;
        zi2 = zi * zi;
        if (zr2 + zi2 >= FOUR_WIDE) break;
        n++;
        sum_re = zr2 - zi2 + cr * UNIT_Q;
        sum_im = 2 * zr * zi + ci * UNIT_Q;
        // arithmetic shift rounds toward minus infinity
        zr = sum_re >>> FRAC_BITS;
        zi = sum_im >>> FRAC_BITS;
      end
      return n[COUNT_BITS-1:0];
    endfunction

    function void note_pixel(logic [INDEX_BITS-1:0] col, logic [INDEX_BITS-1:0] row);
      counts_due = {counts_due, escape_count(col, row)};
    endfunction

    function void check_count(logic [COUNT_BITS-1:0] got);
      logic [COUNT_BITS-1:0] want;
      if (counts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] count %0d arrived with none pending", $time, got);
        return;
      end
      want = counts_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] iteration_count expected %0d got %0d", $time, want, got);
      end
    endfunction

    function int pending();
      return counts_due.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [COORD_W-1:0]     cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_DATA_W-1:0]    s_axis_tdata;   // [11:0] pixel_column, [23:12] pixel_row
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_DATA_W-1:0]    m_axis_tdata;   // [15:0] iteration_count

  escape_count_board sb = new();
  bit                src_idle  = 1'b0;
  bit                sink_idle = 1'b0;
  bit                tail      = 1'b0;
  int unsigned       cycle_count = 0;

  mandelbrot_escape_count_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("mandelbrot_escape_count_core: mismatch");
      $finish;
    end
  end

  // Check every result beat against the oldest predicted count
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_count(m_axis_tdata[COUNT_BITS-1:0]);
  end

  // Stall the result side in random bursts
  initial begin
    int hold;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle && !tail && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    sb.set_reg(idx, val);
  endtask

  // Load a full window and limit; optionally poke an unused index too
  task automatic program_view(logic [COORD_W-1:0] re_org, logic [COORD_W-1:0] im_org,
                              logic [COORD_W-1:0] re_stp, logic [COORD_W-1:0] im_stp,
                              logic [COUNT_BITS-1:0] limit, bit poke_spare);
    write_reg(REG_REAL_ORIGIN, re_org);
    write_reg(REG_IMAG_ORIGIN, im_org);
    write_reg(REG_REAL_STEP, re_stp);
    write_reg(REG_IMAG_STEP, im_stp);
    write_reg(REG_MAX_ITER, {{(COORD_W-COUNT_BITS){1'b0}}, limit});
    if (poke_spare)
      write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), $urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one pixel beat and hold it until taken
  task automatic send_pixel(logic [INDEX_BITS-1:0] col, logic [INDEX_BITS-1:0] row);
    int gap;
    if (src_idle && !tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pixel(col, row);
  endtask

  // Drop valid and wait until every predicted count has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int                    sent_random;
    int                    style;
    int                    pick;
    int                    batch;
    logic [COORD_W-1:0]    re_org, im_org, re_stp, im_stp, mag;
    logic [COUNT_BITS-1:0] limit;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_REAL_ORIGIN;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    sent_random   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window: c = 0 never escapes, runs to the default limit
    send_pixel(12'h000, 12'h000);
    send_pixel(12'hFFF, 12'hFFF);
    wait_drained();

    // Zero limit gives a zero count
    program_view('0, '0, '0, '0, 16'd0, 1'b0);
    send_pixel(12'hFFF, 12'h000);
    wait_drained();

    // Single iteration; writes past the last register must not land
    program_view(VIEW_RE_ORG, VIEW_IM_ORG, VIEW_RE_STP, VIEW_IM_STP, 16'd1, 1'b1);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_LO + 3'd1, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_LO + 3'd2, 32'hFFFF_FFFF);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_pixel(12'h000, 12'h000);
    send_pixel(12'd2731, 12'd2048);
    wait_drained();

    // Saturated coordinates both ways; large components escape at once
    program_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd20, 1'b0);
    send_pixel(12'h000, 12'h000);
    send_pixel(12'hFFF, 12'hFFF);
    wait_drained();
    program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd20, 1'b0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'h001, 12'h001);
    wait_drained();

    // Plane window in view, mixed inside and outside points, with idling
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    program_view(VIEW_RE_ORG, VIEW_IM_ORG, VIEW_RE_STP, VIEW_IM_STP, 16'd64, 1'b0);
    send_pixel(12'h000, 12'h000);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd2731, 12'd2048);
    send_pixel(12'd1365, 12'd2048);
    send_pixel(12'hFFF, 12'h000);
    send_pixel(12'd2048, 12'd3000);
    wait_drained();

    // Largest limit: one point runs it out, one escapes immediately
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    program_view('0, '0, 32'h1000_0000, '0, 16'hFFFF, 1'b0);
    send_pixel(12'h000, 12'h000);
    send_pixel(12'h003, 12'hFFF);
    wait_drained();

    // Random windows; most near the set, some tiny zooms, some raw noise
    while (sent_random < RANDOM_ITEMS) begin
      style = $urandom_range(0, 9);
      pick  = $urandom_range(0, 19);
      if (pick == 0)
        limit = MAX_ITER_RESET;
      else if (pick <= 4)
        limit = COUNT_BITS'($urandom_range(65, 300));
      else
        limit = COUNT_BITS'($urandom_range(1, 64));
      re_org = $urandom_range(0, 805306368) - 32'd671088640;
      im_org = $urandom_range(0, 536870912) - 32'd402653184;
      mag    = (style == 1) ? $urandom_range(1, 64) : $urandom_range(1, 131072);
      re_stp = $urandom_range(0, 1) ? -mag : mag;
      mag    = (style == 1) ? $urandom_range(1, 64) : $urandom_range(1, 131072);
      im_stp = $urandom_range(0, 1) ? -mag : mag;
      if (style == 0) begin
        re_org = $urandom;
        im_org = $urandom;
        re_stp = $urandom;
        im_stp = $urandom;
      end
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      program_view(re_org, im_org, re_stp, im_stp, limit, style == 0);
      batch = (pick == 0) ? 8 : $urandom_range(10, 50);
      repeat (batch) begin
        if (sent_random >= RANDOM_ITEMS - QUIET_TAIL) tail = 1'b1;
        send_pixel(INDEX_BITS'($urandom_range(0, 4095)),
                   INDEX_BITS'($urandom_range(0, 4095)));
        sent_random++;
      end
      wait_drained();
    end

    // Let any stray beat show up before the verdict
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("mandelbrot_escape_count_core: match");
    else
      $display("mandelbrot_escape_count_core: mismatch");
    $finish;
  end

endmodule
